// ===== hdl/ffba_pkg.sv =====
// Shared types and constants of the first-fit block allocator.
// No dependencies; every other file of the block imports this package.
package ffba_pkg;

  localparam int REGION_MAX_DEF   = 65536;
  localparam int GRANULE_BYTES    = 16;
  localparam int REGION_MIN_BYTES = 1024;
  localparam int OVH_SHORT        = 16;
  localparam int OVH_LONG         = 32;

  localparam int CMD_W    = 1;
  localparam int REQ_W    = 16;
  localparam int OFF_W    = 16;
  localparam int STAT_W   = 2;
  localparam int BYTES_W  = 17;
  localparam int BLOCKS_W = 12;
  localparam int CIDX_W   = 1;
  localparam int CDATA_W  = 17;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_REFUSED = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOFIT   = 2'd2;
  localparam logic [STAT_W-1:0] ST_IGNORED = 2'd3;

  localparam logic [CIDX_W-1:0] REG_REGION   = 1'b0;
  localparam logic [CIDX_W-1:0] REG_OVERHEAD = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_READ_CUR, OP_ADV, OP_NOFIT, OP_REFUSE, OP_IGNORE,
    OP_SPLIT_A, OP_SPLIT_B, OP_GRANT, OP_FREE_TAKE, OP_MERGE_PREV,
    OP_READ_NEXT, OP_MERGE_NEXT, OP_FREE_WB, OP_RESP
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_ACHK, S_SPLIT, S_FCHK, S_FPCHK, S_FNRD, S_FNCHK,
    S_FWB, S_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic init_pend;
    logic is_free;
    logic alloc_refuse;
    logic free_bad;
    logic in_lim;
    logic live;
    logic used;
    logic fit;
    logic split;
    logic hasnext;
    logic hasprev;
    logic p_free;
    logic cur_hasnext;
    logic nx_free;
    logic out_full;
  } dp_stat_t;

endpackage

// ===== hdl/ffba_req_if.sv =====
// Request channel of the allocator: command, size and offset.
// Depends on ffba_pkg.
interface ffba_req_if import ffba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [REQ_W-1:0] request_bytes;
  logic [OFF_W-1:0] free_offset;

  modport source(output valid, cmd, request_bytes, free_offset, input ready);
  modport sink(input valid, cmd, request_bytes, free_offset, output ready);
endinterface

// ===== hdl/ffba_rsp_if.sv =====
// Result channel of the allocator: status, offset and usage counters.
// Depends on ffba_pkg.
interface ffba_rsp_if import ffba_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [OFF_W-1:0]    data_offset;
  logic [BYTES_W-1:0]  bytes_in_use;
  logic [BLOCKS_W-1:0] blocks_in_use;

  modport source(output valid, status, data_offset, bytes_in_use, blocks_in_use,
                 input ready);
  modport sink(input valid, status, data_offset, bytes_in_use, blocks_in_use,
               output ready);
endinterface

// ===== hdl/ffba_cfg_if.sv =====
// Configuration write channel of the allocator: register index and data.
// Depends on ffba_pkg.
interface ffba_cfg_if import ffba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [CDATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/ffba_datapath.sv =====
// Datapath of the allocator: header memories, walk registers, counters,
// configuration and result register. Driven by ffba_ctrl; depends on ffba_pkg.
module ffba_datapath import ffba_pkg::*; #(
  parameter int REGION_MAX = REGION_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_op_t              op,
  input  logic [CMD_W-1:0]    req_cmd,
  input  logic [REQ_W-1:0]    req_bytes,
  input  logic [OFF_W-1:0]    req_off,
  input  logic                cfg_we,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [CDATA_W-1:0]  cfg_data,
  input  logic                rsp_ready,
  output dp_stat_t            stat,
  output logic                rsp_valid,
  output logic [STAT_W-1:0]   rsp_status,
  output logic [OFF_W-1:0]    rsp_offset,
  output logic [BYTES_W-1:0]  rsp_bytes,
  output logic [BLOCKS_W-1:0] rsp_blocks
);

  localparam int SLOT_COUNT = REGION_MAX / GRANULE_BYTES;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int IDX_W      = SLOT_W + 1;
  localparam int REG_W      = $clog2(REGION_MAX) + 1;
  localparam int SIZE_W     = $clog2(REGION_MAX);
  localparam int HDR_W      = SIZE_W + 4;
  localparam int CW         = ((SIZE_W > 17) ? SIZE_W : 17) + 2;
  localparam int CEW        = (REG_W > 17) ? REG_W : 17;
  localparam int LW         = (IDX_W > 13) ? IDX_W : 13;
  localparam int OW         = IDX_W + 5;
  localparam int REGION_RESET = (REGION_MAX < 65536) ? REGION_MAX : 65536;

  // Header entry: live, in use, data size, predecessor present, successor present.
  logic [HDR_W-1:0]  hdr_mem [SLOT_COUNT];
  logic [SLOT_W-1:0] prev_mem [SLOT_COUNT];

  logic [REG_W-1:0]    eff_region;
  logic                ovh32;
  logic                init_pend;
  logic [SLOT_W-1:0]   clr_addr;
  logic                space;
  logic [BYTES_W-1:0]  used_bytes;
  logic [BLOCKS_W-1:0] used_blocks;

  logic              is_free;
  logic              off_bad;
  logic [16:0]       need;
  logic [IDX_W-1:0]  cur;
  logic [IDX_W-1:0]  sv_slot;
  logic              sv_hasnext;
  logic [IDX_W-1:0]  p_slot;
  logic [IDX_W-1:0]  nx_slot;
  logic [SIZE_W-1:0] cur_size;
  logic              cur_hasprev;
  logic              cur_hasnext;
  logic [STAT_W-1:0] res_st;
  logic [OFF_W-1:0]  res_off;

  logic              rd_live, rd_used, rd_hasprev, rd_hasnext;
  logic [SIZE_W-1:0] rd_size;
  logic [SLOT_W-1:0] rd_prev;

  logic [CW-1:0]     ovh_c, rd_size_c, need_c;
  logic [IDX_W-1:0]  limit, succ_rd, split_r, nxt, mp_succ, nn;
  logic [SIZE_W-1:0] split_size_s, mp_size, mn_size;
  logic [OFF_W-1:0]  cur_off;
  logic [12:0]       fs;
  logic [CEW-1:0]    rc;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              hdr_we, prev_we;
  logic [IDX_W-1:0]  hdr_wa, prev_wa;
  logic [HDR_W-1:0]  hdr_wd;
  logic [SLOT_W-1:0] prev_wd;

  assign ovh_c     = ovh32 ? CW'(OVH_LONG) : CW'(OVH_SHORT);
  assign rd_size_c = CW'(rd_size);
  assign need_c    = CW'(need);
  assign limit     = eff_region[REG_W-1:4];

  assign succ_rd      = cur + IDX_W'((ovh_c + rd_size_c) >> 4);
  assign split_r      = cur + IDX_W'((rd_size_c - need_c) >> 4);
  assign split_size_s = SIZE_W'(rd_size_c - need_c - ovh_c);
  assign mp_size      = SIZE_W'(rd_size_c + CW'(cur_size) + ovh_c);
  assign mp_succ      = p_slot + IDX_W'((ovh_c + CW'(mp_size)) >> 4);
  assign nxt          = cur + IDX_W'((ovh_c + CW'(cur_size)) >> 4);
  assign mn_size      = SIZE_W'(CW'(cur_size) + rd_size_c + ovh_c);
  assign nn           = cur + IDX_W'((ovh_c + CW'(mn_size)) >> 4);
  assign cur_off      = OFF_W'(OW'({cur, 4'h0}) + OW'(GRANULE_BYTES));
  assign fs           = {1'b0, req_off[15:4]} - 13'd1;

  always_comb begin
    rc = CEW'({cfg_data[16:4], 4'h0});
    if (rc < CEW'(REGION_MIN_BYTES)) rc = CEW'(REGION_MIN_BYTES);
    if (rc > CEW'(REGION_MAX)) rc = CEW'(REGION_MAX);
  end

  always_comb begin
    stat.init_pend    = init_pend;
    stat.is_free      = is_free;
    stat.alloc_refuse = (need == 17'd0) || !space;
    stat.free_bad     = off_bad;
    stat.in_lim       = cur < limit;
    stat.live         = rd_live;
    stat.used         = rd_used;
    stat.fit          = rd_live && !rd_used && (rd_size_c >= need_c);
    stat.split        = rd_size_c > (need_c + ovh_c);
    stat.hasnext      = rd_hasnext;
    stat.hasprev      = rd_hasprev;
    stat.p_free       = rd_live && !rd_used;
    stat.cur_hasnext  = cur_hasnext;
    stat.nx_free      = rd_live && !rd_used && (nx_slot < IDX_W'(SLOT_COUNT));
    stat.out_full     = rsp_valid && !rsp_ready;
  end

  // Memory port selection for the current command.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur;
    hdr_we  = 1'b0;
    hdr_wa  = cur;
    hdr_wd  = {1'b1, 1'b0, cur_size, cur_hasprev, cur_hasnext};
    prev_we = 1'b0;
    prev_wa = cur;
    prev_wd = rd_prev;
    unique case (op)
      OP_READ_CUR: rd_en = 1'b1;
      OP_ADV: begin
        rd_en   = 1'b1;
        rd_addr = succ_rd;
      end
      OP_FREE_TAKE: begin
        rd_en   = 1'b1;
        rd_addr = IDX_W'(rd_prev);
      end
      OP_READ_NEXT: begin
        rd_en   = 1'b1;
        rd_addr = nxt;
      end
      OP_SPLIT_A: begin
        hdr_we  = 1'b1;
        hdr_wd  = {1'b1, 1'b0, split_size_s, rd_hasprev, 1'b1};
        prev_we = rd_hasnext;
        prev_wa = succ_rd;
        prev_wd = SLOT_W'(split_r);
      end
      OP_SPLIT_B: begin
        hdr_we  = 1'b1;
        hdr_wd  = {1'b1, 1'b1, SIZE_W'(need), 1'b1, sv_hasnext};
        prev_we = 1'b1;
        prev_wd = SLOT_W'(sv_slot);
      end
      OP_GRANT: begin
        hdr_we = 1'b1;
        hdr_wd = {1'b1, 1'b1, rd_size, rd_hasprev, rd_hasnext};
      end
      OP_MERGE_PREV: begin
        hdr_we  = 1'b1;
        hdr_wd  = {1'b0, 1'b0, cur_size, 1'b0, 1'b0};
        prev_we = cur_hasnext;
        prev_wa = mp_succ;
        prev_wd = SLOT_W'(p_slot);
      end
      OP_MERGE_NEXT: begin
        hdr_we  = 1'b1;
        hdr_wa  = nx_slot;
        hdr_wd  = {1'b0, 1'b0, rd_size, 1'b0, 1'b0};
        prev_we = rd_hasnext;
        prev_wa = nn;
        prev_wd = SLOT_W'(cur);
      end
      OP_FREE_WB: hdr_we = 1'b1;
      default: ;
    endcase
    // After reset or a configuration write, one pass over all slots clears
    // every live mark and makes slot 0 one free block.
    if (init_pend) begin
      hdr_we = 1'b1;
      hdr_wa = IDX_W'(clr_addr);
      hdr_wd = '0;
      if (clr_addr == '0)
        hdr_wd = {1'b1, 1'b0,
                  SIZE_W'(CW'(eff_region) - ovh_c), 1'b0, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) hdr_mem[hdr_wa[SLOT_W-1:0]] <= hdr_wd;
    if (prev_we) prev_mem[prev_wa[SLOT_W-1:0]] <= prev_wd;
    if (rd_en) begin
      {rd_live, rd_used, rd_size, rd_hasprev, rd_hasnext} <=
        hdr_mem[rd_addr[SLOT_W-1:0]];
      rd_prev <= prev_mem[rd_addr[SLOT_W-1:0]];
    end
  end

  // Control and counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      eff_region  <= REG_W'(REGION_RESET);
      ovh32       <= 1'b0;
      init_pend   <= 1'b1;
      clr_addr    <= '0;
      space       <= 1'b1;
      used_bytes  <= '0;
      used_blocks <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (init_pend) begin
        clr_addr <= clr_addr + SLOT_W'(1);
        if (clr_addr == SLOT_W'(SLOT_COUNT - 1)) init_pend <= 1'b0;
      end
      if (rsp_ready) rsp_valid <= 1'b0;
      unique case (op)
        OP_NOFIT: space <= 1'b0;
        OP_SPLIT_B: begin
          used_bytes  <= used_bytes + BYTES_W'(need);
          used_blocks <= used_blocks + BLOCKS_W'(1);
        end
        OP_GRANT: begin
          used_bytes  <= used_bytes + BYTES_W'(rd_size);
          used_blocks <= used_blocks + BLOCKS_W'(1);
        end
        OP_FREE_TAKE: begin
          space       <= 1'b1;
          used_bytes  <= used_bytes - BYTES_W'(rd_size);
          used_blocks <= used_blocks - BLOCKS_W'(1);
        end
        OP_RESP: rsp_valid <= 1'b1;
        default: ;
      endcase
      if (cfg_we) begin
        unique case (cfg_index)
          REG_REGION:   eff_region <= REG_W'(rc);
          REG_OVERHEAD: ovh32 <= cfg_data[5];
        endcase
        init_pend   <= 1'b1;
        clr_addr    <= '0;
        space       <= 1'b1;
        used_bytes  <= '0;
        used_blocks <= '0;
      end
    end
  end

  // Walk and result registers.
  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        is_free <= (req_cmd == CMD_FREE);
        need    <= ({1'b0, req_bytes} + 17'd15) & ~17'hF;
        off_bad <= (req_off == '0) || (req_off[3:0] != 4'h0) ||
                   (LW'(fs) >= LW'(limit));
        cur     <= (req_cmd == CMD_FREE) ? IDX_W'(fs) : '0;
      end
      OP_ADV: cur <= succ_rd;
      OP_NOFIT: begin
        res_st  <= ST_NOFIT;
        res_off <= '0;
      end
      OP_REFUSE: begin
        res_st  <= ST_REFUSED;
        res_off <= '0;
      end
      OP_IGNORE: begin
        res_st  <= ST_IGNORED;
        res_off <= '0;
      end
      OP_SPLIT_A: begin
        sv_slot    <= cur;
        sv_hasnext <= rd_hasnext;
        cur        <= split_r;
      end
      OP_SPLIT_B, OP_GRANT: begin
        res_st  <= ST_OK;
        res_off <= cur_off;
      end
      OP_FREE_TAKE: begin
        res_st      <= ST_OK;
        res_off     <= '0;
        cur_size    <= rd_size;
        cur_hasprev <= rd_hasprev;
        cur_hasnext <= rd_hasnext;
        p_slot      <= IDX_W'(rd_prev);
      end
      OP_MERGE_PREV: begin
        cur         <= p_slot;
        cur_size    <= mp_size;
        cur_hasprev <= rd_hasprev;
      end
      OP_READ_NEXT: nx_slot <= nxt;
      OP_MERGE_NEXT: begin
        cur_size    <= mn_size;
        cur_hasnext <= rd_hasnext;
      end
      OP_RESP: begin
        rsp_status <= res_st;
        rsp_offset <= res_off;
        rsp_bytes  <= used_bytes;
        rsp_blocks <= used_blocks;
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/ffba_ctrl.sv =====
// Controller state machine of the allocator: sequences the header walk,
// split, free and merge steps as commands to ffba_datapath. Depends on ffba_pkg.
module ffba_ctrl import ffba_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  dp_stat_t stat,
  output logic     req_ready,
  output dp_op_t   op
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (req_valid && !stat.init_pend) state_next = S_START;
      S_START: begin
        if (stat.is_free) state_next = stat.free_bad ? S_RESP : S_FCHK;
        else state_next = stat.alloc_refuse ? S_RESP : S_ACHK;
      end
      S_ACHK: begin
        priority if (!stat.in_lim || !stat.live) state_next = S_RESP;
        else if (stat.fit && stat.split) state_next = S_SPLIT;
        else if (stat.fit) state_next = S_RESP;
        else if (!stat.hasnext) state_next = S_RESP;
        else state_next = S_ACHK;
      end
      S_SPLIT: state_next = S_RESP;
      S_FCHK: begin
        priority if (!stat.live || !stat.used) state_next = S_RESP;
        else if (stat.hasprev) state_next = S_FPCHK;
        else state_next = S_FNRD;
      end
      S_FPCHK: state_next = S_FNRD;
      S_FNRD:  state_next = stat.cur_hasnext ? S_FNCHK : S_FWB;
      S_FNCHK: state_next = S_FWB;
      S_FWB:   state_next = S_RESP;
      S_RESP:  if (!stat.out_full) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    op        = OP_NONE;
    req_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = !stat.init_pend;
        if (req_valid && !stat.init_pend) op = OP_LOAD;
      end
      S_START: begin
        if (stat.is_free) op = stat.free_bad ? OP_IGNORE : OP_READ_CUR;
        else op = stat.alloc_refuse ? OP_REFUSE : OP_READ_CUR;
      end
      S_ACHK: begin
        priority if (!stat.in_lim || !stat.live) op = OP_NOFIT;
        else if (stat.fit && stat.split) op = OP_SPLIT_A;
        else if (stat.fit) op = OP_GRANT;
        else if (!stat.hasnext) op = OP_NOFIT;
        else op = OP_ADV;
      end
      S_SPLIT: op = OP_SPLIT_B;
      S_FCHK:  op = (!stat.live || !stat.used) ? OP_IGNORE : OP_FREE_TAKE;
      S_FPCHK: op = stat.p_free ? OP_MERGE_PREV : OP_NONE;
      S_FNRD:  op = stat.cur_hasnext ? OP_READ_NEXT : OP_NONE;
      S_FNCHK: op = stat.nx_free ? OP_MERGE_NEXT : OP_NONE;
      S_FWB:   op = OP_FREE_WB;
      S_RESP:  op = stat.out_full ? OP_NONE : OP_RESP;
      default: op = OP_NONE;
    endcase
  end

endmodule

// ===== hdl/first_fit_block_allocator_unit.sv =====
// First-fit block allocator, top level. One word at a time: an allocate walks the
// blocks from slot 0 and adds a split step when the block is split; refusals skip the
// walk; a free is ignored at once or after its header check, else it may merge both ways.
// A stalled result holds the unit until taken. The walk over the header memory, one block
// per cycle through its single registered read port, sets the allocate latency.
// Synchronous reset sets the region to its full size; after reset or any configuration
// write a pass of one cycle per header slot (4096 at the default REGION_MAX) clears the
// store and makes slot 0 one free block, and requests wait until it ends.
module first_fit_block_allocator_unit import ffba_pkg::*; #(
  parameter int REGION_MAX = REGION_MAX_DEF
) (
  input logic         clk,
  input logic         rst,
  ffba_req_if.sink    req,
  ffba_rsp_if.source  rsp,
  ffba_cfg_if.sink    cfg
);

  dp_op_t   op;
  dp_stat_t stat;

  assign cfg.ready = 1'b1;

  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .stat      (stat),
    .req_ready (req.ready),
    .op        (op)
  );

  ffba_datapath #(.REGION_MAX(REGION_MAX)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .req_cmd    (req.cmd),
    .req_bytes  (req.request_bytes),
    .req_off    (req.free_offset),
    .cfg_we     (cfg.valid),
    .cfg_index  (cfg.index),
    .cfg_data   (cfg.data),
    .rsp_ready  (rsp.ready),
    .stat       (stat),
    .rsp_valid  (rsp.valid),
    .rsp_status (rsp.status),
    .rsp_offset (rsp.data_offset),
    .rsp_bytes  (rsp.bytes_in_use),
    .rsp_blocks (rsp.blocks_in_use)
  );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench of the first-fit block allocator unit.
// Drives the request, result and configuration channels from ffba_pkg and the
// ffba_*_if interfaces, and checks each result word against a built-in predictor.
module tb_top;
  import ffba_pkg::*;

  localparam int SLOTS = REGION_MAX_DEF / GRANULE_BYTES;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [REQ_W-1:0] request_bytes;
    logic [OFF_W-1:0] free_offset;
  } alloc_word_t;

  typedef struct {
    logic [STAT_W-1:0]   status;
    logic [OFF_W-1:0]    data_offset;
    logic [BYTES_W-1:0]  bytes_in_use;
    logic [BLOCKS_W-1:0] blocks_in_use;
  } usage_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ffba_req_if req_ch ();
  ffba_rsp_if rsp_ch ();
  ffba_cfg_if cfg_ch ();

  first_fit_block_allocator_unit dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch)
  );

  always #4 clk = ~clk;

  // Predictor state: one header per granule slot.
  int unsigned blk_size [SLOTS];
  int unsigned blk_prev [SLOTS];
  bit          blk_live [SLOTS];
  bit          blk_used [SLOTS];
  bit          blk_hasprev [SLOTS];
  bit          blk_hasnext [SLOTS];
  bit          can_alloc;
  int unsigned bytes_used;
  int unsigned blocks_used;
  logic [16:0] region_reg;
  logic [5:0]  overhead_reg;
  int unsigned region_eff;
  int unsigned overhead_eff;

  alloc_word_t pending_words[$];
  usage_word_t expected_results[$];
  int unsigned granted_offsets[$];
  int unsigned last_grant;
  int          errors = 0;
  int          words_sent = 0;
  int          results_checked = 0;
  int          grants_seen = 0;
  int          nofits_seen = 0;
  bit          drv_busy = 1'b0;
  bit          burst_mode = 1'b0;

  function automatic void rebuild_store();
    int unsigned r;
    r = region_reg & 17'h1FFF0;
    if (r < REGION_MIN_BYTES) r = REGION_MIN_BYTES;
    if (r > REGION_MAX_DEF) r = REGION_MAX_DEF;
    region_eff = r;
    overhead_eff = overhead_reg[5] ? OVH_LONG : OVH_SHORT;
    for (int i = 0; i < SLOTS; i++) begin
      blk_size[i] = 0; blk_prev[i] = 0; blk_live[i] = 0; blk_used[i] = 0;
      blk_hasprev[i] = 0; blk_hasnext[i] = 0;
    end
    blk_live[0] = 1;
    blk_size[0] = region_eff - overhead_eff;
    can_alloc = 1;
    bytes_used = 0;
    blocks_used = 0;
    granted_offsets.delete();
  endfunction

  function automatic int unsigned next_slot(int unsigned s);
    return s + (overhead_eff + blk_size[s]) / GRANULE_BYTES;
  endfunction

  function automatic void drop_offset(int unsigned off);
    for (int i = 0; i < granted_offsets.size(); i++)
      if (granted_offsets[i] == off) begin
        granted_offsets.delete(i);
        break;
      end
  endfunction

  function automatic usage_word_t predict_usage(alloc_word_t w);
    usage_word_t res;
    int unsigned need, s, r, n, p, nn;
    bit done;
    res.status = ST_OK;
    res.data_offset = '0;
    done = 0;
    if (w.cmd == CMD_ALLOC) begin
      if (w.request_bytes == 0 || !can_alloc) begin
        res.status = ST_REFUSED;
        done = 1;
      end
      need = (w.request_bytes + 15) & ~32'd15;
      s = 0;
      for (int steps = 0; steps < SLOTS && !done; steps++) begin
        if (s >= region_eff / GRANULE_BYTES || !blk_live[s]) break;
        if (!blk_used[s] && blk_size[s] >= need) begin
          if (blk_size[s] > need + overhead_eff) begin
            r = s + (blk_size[s] - need) / GRANULE_BYTES;
            if (blk_hasnext[s]) begin
              n = next_slot(s);
              if (n < SLOTS) blk_prev[n] = r;
            end
            if (r >= SLOTS) break;
            blk_live[r] = 1; blk_used[r] = 0; blk_size[r] = need;
            blk_hasprev[r] = 1; blk_prev[r] = s; blk_hasnext[r] = blk_hasnext[s];
            blk_size[s] -= need + overhead_eff;
            blk_hasnext[s] = 1;
            s = r;
          end
          blk_used[s] = 1;
          bytes_used = (bytes_used + blk_size[s]) & 17'h1FFFF;
          blocks_used = (blocks_used + 1) & 12'hFFF;
          res.data_offset = OFF_W'(s * GRANULE_BYTES + 16);
          granted_offsets.push_back(s * GRANULE_BYTES + 16);
          last_grant = s * GRANULE_BYTES + 16;
          grants_seen++;
          done = 1;
        end
        if (!done) begin
          if (!blk_hasnext[s]) break;
          s = next_slot(s);
        end
      end
      if (!done) begin
        can_alloc = 0;
        res.status = ST_NOFIT;
        nofits_seen++;
      end
    end else begin
      s = (w.free_offset - 16) / GRANULE_BYTES;
      if (w.free_offset == 0 || w.free_offset[3:0] != 0 ||
          s >= region_eff / GRANULE_BYTES || !blk_live[s] || !blk_used[s]) begin
        res.status = ST_IGNORED;
      end else begin
        drop_offset(w.free_offset);
        blk_used[s] = 0;
        can_alloc = 1;
        bytes_used = (bytes_used - blk_size[s]) & 17'h1FFFF;
        blocks_used = (blocks_used - 1) & 12'hFFF;
        if (blk_hasprev[s]) begin
          p = blk_prev[s];
          if (p < SLOTS && blk_live[p] && !blk_used[p]) begin
            blk_size[p] += blk_size[s] + overhead_eff;
            blk_hasnext[p] = blk_hasnext[s];
            if (blk_hasnext[s]) begin
              n = next_slot(p);
              if (n < SLOTS) blk_prev[n] = p;
            end
            blk_live[s] = 0;
            s = p;
          end
        end
        if (blk_hasnext[s]) begin
          n = next_slot(s);
          if (n < SLOTS && blk_live[n] && !blk_used[n]) begin
            blk_size[s] += blk_size[n] + overhead_eff;
            blk_hasnext[s] = blk_hasnext[n];
            if (blk_hasnext[s]) begin
              nn = next_slot(s);
              if (nn < SLOTS) blk_prev[nn] = s;
            end
            blk_live[n] = 0;
          end
        end
      end
    end
    res.bytes_in_use = BYTES_W'(bytes_used);
    res.blocks_in_use = BLOCKS_W'(blocks_used);
    return res;
  endfunction

  function automatic int unsigned draw_wait();
    return burst_mode ? 0 : $urandom_range(0, 18);
  endfunction

  // Request driver: one word per handshake, with a random gap after each.
  alloc_word_t cur_word;
  int unsigned drv_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      drv_busy = 1'b0;
      drv_gap = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_results.push_back(predict_usage(cur_word));
        words_sent++;
        drv_busy = 1'b0;
        drv_gap = draw_wait();
      end
      if (!drv_busy) begin
        if (drv_gap > 0) drv_gap--;
        else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          drv_busy = 1'b1;
        end
      end
      req_ch.valid <= drv_busy;
      req_ch.cmd <= cur_word.cmd;
      req_ch.request_bytes <= cur_word.request_bytes;
      req_ch.free_offset <= cur_word.free_offset;
    end
  end

  // Result monitor: random stalls on ready, field-by-field comparison.
  int unsigned mon_stall = 0;
  always @(posedge clk) begin
    usage_word_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      mon_stall = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          $error("unexpected result word, status %0d", rsp_ch.status);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, rsp_ch.status);
            errors++;
          end
          if (rsp_ch.data_offset !== want.data_offset) begin
            $error("data_offset: expected %0d actual %0d",
                   want.data_offset, rsp_ch.data_offset);
            errors++;
          end
          if (rsp_ch.bytes_in_use !== want.bytes_in_use) begin
            $error("bytes_in_use: expected %0d actual %0d",
                   want.bytes_in_use, rsp_ch.bytes_in_use);
            errors++;
          end
          if (rsp_ch.blocks_in_use !== want.blocks_in_use) begin
            $error("blocks_in_use: expected %0d actual %0d",
                   want.blocks_in_use, rsp_ch.blocks_in_use);
            errors++;
          end
        end
        mon_stall = draw_wait();
      end else if (mon_stall > 0) begin
        mon_stall--;
      end
      rsp_ch.ready <= (mon_stall == 0);
    end
  end

  task automatic send(logic [CMD_W-1:0] cmd, int unsigned bytes, int unsigned off);
    alloc_word_t w;
    while (pending_words.size() != 0 || drv_busy) @(posedge clk);
    w.cmd = cmd;
    w.request_bytes = REQ_W'(bytes);
    w.free_offset = OFF_W'(off);
    pending_words.push_back(w);
    @(posedge clk);
    // Return only once the word is accepted and predicted, so frees can name
    // fresh grants.
    while (pending_words.size() != 0 || drv_busy) @(posedge clk);
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || drv_busy || expected_results.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_REGION) region_reg = value;
    else overhead_reg = value[5:0];
    rebuild_store();
  endtask

  task automatic directed_words();
    int unsigned a, b, c;
    send(CMD_ALLOC, 0, 0);
    send(CMD_FREE, 0, 0);
    send(CMD_FREE, 0, 8);
    send(CMD_FREE, 0, 16'hFFF0);
    send(CMD_FREE, 0, 16);
    send(CMD_ALLOC, 1, 16'hFFFF);
    a = last_grant;
    send(CMD_FREE, 0, a);
    send(CMD_FREE, 0, a);
    send(CMD_ALLOC, 16, 0); a = last_grant;
    send(CMD_ALLOC, 17, 0); b = last_grant;
    send(CMD_ALLOC, 48, 0); c = last_grant;
    send(CMD_FREE, 0, b);
    send(CMD_FREE, 0, a);
    send(CMD_FREE, 0, c);
    // Take the whole region with one unsplit block, then release it.
    send(CMD_ALLOC, region_eff - overhead_eff, 0); a = last_grant;
    send(CMD_FREE, 16'hFFFF, a);
    send(CMD_ALLOC, 100, 0); a = last_grant;
    send(CMD_ALLOC, 16'hFFFF, 0);
    send(CMD_ALLOC, 5, 0);
    send(CMD_FREE, 0, a);
    send(CMD_ALLOC, 5, 0);
  endtask

  task automatic random_words(int count);
    int unsigned pick, bytes, off;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 55) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) bytes = $urandom_range(1, 64);
        else if (pick < 90) bytes = $urandom_range(65, 1024);
        else if (pick < 98) bytes = $urandom_range(1025, 8192);
        else bytes = $urandom_range(0, 65535);
        send(CMD_ALLOC, bytes, $urandom());
      end else begin
        if (granted_offsets.size() > 0 && $urandom_range(0, 99) < 80)
          off = granted_offsets[$urandom_range(0, granted_offsets.size() - 1)];
        else if ($urandom_range(0, 1)) off = $urandom_range(0, 65535) & 16'hFFF0;
        else off = $urandom_range(0, 65535);
        send(CMD_FREE, $urandom(), off);
      end
    end
  endtask

  initial begin
    req_ch.valid = 1'b0; req_ch.cmd = CMD_ALLOC;
    req_ch.request_bytes = '0; req_ch.free_offset = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = REG_REGION; cfg_ch.data = '0;
    region_reg = 17'(REGION_MAX_DEF);
    overhead_reg = 6'(OVH_SHORT);
    rebuild_store();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);

    directed_words();
    random_words(150);
    drain();
    write_reg(REG_REGION, CDATA_W'(REGION_MIN_BYTES));
    write_reg(REG_OVERHEAD, CDATA_W'(OVH_LONG));
    directed_words();
    random_words(150);
    drain();
    write_reg(REG_OVERHEAD, CDATA_W'(OVH_SHORT));
    random_words(130);
    drain();
    // Unaligned and undersized region values, then odd overhead codes.
    write_reg(REG_REGION, CDATA_W'(1000));
    write_reg(REG_OVERHEAD, CDATA_W'(33));
    random_words(130);
    drain();
    write_reg(REG_REGION, 17'h1FFFF);
    write_reg(REG_OVERHEAD, CDATA_W'(0));
    directed_words();
    random_words(150);
    drain();
    write_reg(REG_REGION, CDATA_W'(4104));
    write_reg(REG_OVERHEAD, CDATA_W'(63));
    random_words(150);
    drain();

    $display("Sent %0d words, checked %0d results over six region settings.",
             words_sent, results_checked);
    $display("Grants %0d, no-fit refusals %0d.", grants_seen, nofits_seen);
    if (errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  initial begin
    #400000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ffba_pkg.sv
hdl/ffba_req_if.sv
hdl/ffba_rsp_if.sv
hdl/ffba_cfg_if.sv
hdl/ffba_datapath.sv
hdl/ffba_ctrl.sv
hdl/first_fit_block_allocator_unit.sv
dv/tb_top.sv
